// ----- hdl/ura_pkg.sv -----
package ura_pkg;

   // field widths
   localparam int SAMPLE_W = 11;
   localparam int COUNT_W = 16;
   localparam int LEVEL_W = 3;
   localparam int TONE_W = 16;
   localparam int DIGIT_W = 4;
   localparam int NDIG_W = 2;
   localparam int RSP_PAD_W = 4;

   // defaults
   localparam int AVG_DEPTH_DEFAULT = 10;
   localparam logic [SAMPLE_W-1:0] MAX_DIST_RESET = 11'd400;

   // travel / 58 as (travel * 72316) >> 22, exact for 16-bit travel
   localparam int ECHO_SHIFT = 22;
   localparam int ECHO_RECIP_W = 17;
   localparam logic [ECHO_RECIP_W-1:0] ECHO_RECIP = 17'd72316;

   // alarm levels
   localparam logic [LEVEL_W-1:0] LVL_NONE = 3'd0;
   localparam logic [LEVEL_W-1:0] LVL_1 = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_2 = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_3 = 3'd3;
   localparam logic [LEVEL_W-1:0] LVL_4 = 3'd4;
   localparam logic [LEVEL_W-1:0] LVL_5 = 3'd5;

   // result word, last field in the lowest bits
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [NDIG_W-1:0]    digit_count;
      logic [DIGIT_W-1:0]   hundreds_digit;
      logic [DIGIT_W-1:0]   tens_digit;
      logic [DIGIT_W-1:0]   ones_digit;
      logic [TONE_W-1:0]    tone_duty;
      logic [TONE_W-1:0]    tone_period;
      logic [LEVEL_W-1:0]   alarm_level;
      logic [SAMPLE_W-1:0]  distance_cm;
   } result_type;

   // exact distances that raise the alarm
   function automatic logic [LEVEL_W-1:0] level_of(input logic [SAMPLE_W-1:0] dist_cm);
      logic [LEVEL_W-1:0] lvl;
      case (dist_cm)
         11'd5:   lvl = LVL_5;
         11'd10:  lvl = LVL_4;
         11'd15:  lvl = LVL_3;
         11'd20:  lvl = LVL_2;
         11'd25:  lvl = LVL_1;
         default: lvl = LVL_NONE;
      endcase
      return lvl;
   endfunction

   // tone period per level
   function automatic logic [TONE_W-1:0] tone_period_of(input logic [LEVEL_W-1:0] lvl);
      logic [TONE_W-1:0] p;
      case (lvl)
         LVL_1:   p = 16'd12134;
         LVL_2:   p = 16'd3405;
         LVL_3:   p = 16'd2272;
         LVL_4:   p = 16'd1516;
         LVL_5:   p = 16'd1136;
         default: p = '0;
      endcase
      return p;
   endfunction

   // tone compare count per level
   function automatic logic [TONE_W-1:0] tone_duty_of(input logic [LEVEL_W-1:0] lvl);
      logic [TONE_W-1:0] d;
      case (lvl)
         LVL_1:   d = 16'd6067;
         LVL_2:   d = 16'd1702;
         LVL_3:   d = 16'd1136;
         LVL_4:   d = 16'd758;
         LVL_5:   d = 16'd568;
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

// ----- hdl/ura_cell.sv -----
module ura_cell
   import ura_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic [SAMPLE_W-1:0] sample_in,
   output logic [SAMPLE_W-1:0] sample_out
);

   logic [SAMPLE_W-1:0] sample_ff;

   // one history entry, takes its neighbor's value on a shift
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

// ----- hdl/ura_history.sv -----
module ura_history
   import ura_pkg::*;
#(
   parameter int AVG_DEPTH = AVG_DEPTH_DEFAULT,
   localparam int SUM_W = SAMPLE_W + $clog2(AVG_DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic [SAMPLE_W-1:0] sample,
   output logic [SUM_W-1:0]    sum
);

   logic [SAMPLE_W-1:0] tap [AVG_DEPTH+1];
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;

   assign tap[0] = sample;

   // row of cells, newest entry at the head
   for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_cell
      ura_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .sample_in  (tap[i]),
         .sample_out (tap[i+1])
      );
   end

   // running sum: add the new entry, drop the one falling off the end
   assign sum_in = sum_ff + SUM_W'(sample) - SUM_W'(tap[AVG_DEPTH]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (shift_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ----- hdl/ura_format.sv -----
module ura_format
   import ura_pkg::*;
(
   input  logic [SAMPLE_W-1:0] dist_cm,
   output result_type          result
);

   logic [22:0]         p10;
   logic [22:0]         p100;
   logic [7:0]          q10;
   logic [4:0]          q100;
   logic [SAMPLE_W-1:0] ones_w;
   logic [7:0]          tens_w;
   logic [4:0]          hund_w;
   logic [LEVEL_W-1:0]  lvl;

   // dist_cm / 10 and dist_cm / 100 by reciprocal
   assign p10 = 23'(dist_cm) * 23'(3277);
   assign p100 = 23'(dist_cm) * 23'(2622);
   assign q10 = p10[15 +: 8];
   assign q100 = p100[18 +: 5];

   // remainders
   assign ones_w = dist_cm - ({q10, 3'b000} + {2'b00, q10, 1'b0});
   assign tens_w = q10 - ({q100, 3'b000} + {2'b00, q100, 1'b0});

   // hundreds modulo ten
   always_comb begin
      if (q100 >= 5'd20) begin
         hund_w = q100 - 5'd20;
      end else if (q100 >= 5'd10) begin
         hund_w = q100 - 5'd10;
      end else begin
         hund_w = q100;
      end
   end

   assign lvl = level_of(dist_cm);

   always_comb begin
      result = '0;
      result.distance_cm = dist_cm;
      result.alarm_level = lvl;
      result.tone_period = tone_period_of(lvl);
      result.tone_duty = tone_duty_of(lvl);
      result.ones_digit = ones_w[DIGIT_W-1:0];
      result.tens_digit = tens_w[DIGIT_W-1:0];
      result.hundreds_digit = hund_w[DIGIT_W-1:0];
      if (dist_cm > 11'd99) begin
         result.digit_count = 2'd3;
      end else if (dist_cm > 11'd9) begin
         result.digit_count = 2'd2;
      end else begin
         result.digit_count = 2'd1;
      end
   end

endmodule

// ----- hdl/ultrasonic_range_alarm_unit.sv -----
// ultrasonic range alarm
// req channel: one word per echo, start and end timer captures. the travel
// time wraps at 16 bits and is turned into centimetres (divide by 58).
// the sample shifts through a row of AVG_DEPTH history cells that keep a
// running sum; the mean is clamped to the max_distance register.
// rsp channel: one word per req word, in order: clamped distance, alarm
// level with tone period and duty, three decimal digits and digit count.
// csr channel: writes max_distance (reset value 400), always ready. write
// it only while no word is in flight.
// pipeline: five register stages (travel, sample, running sum, clamped
// distance, output), the first loaded at the edge that takes the req word.
// throughput: one word per cycle while rsp is not stalled; the five register stages move together.
// when the receiver stalls a finished word waits in the output register
// and the pipeline holds, so req_tready drops until rsp is taken.
// reset clears the history, the running sum, all valid flags and loads
// max_distance with 400; the block takes words on the next cycle.
module ultrasonic_range_alarm_unit
   import ura_pkg::*;
#(
   parameter int AVG_DEPTH = AVG_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // start_count[15:0], end_count[31:16]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,   // distance_cm[10:0], alarm_level[13:11],
                                            // tone_period[29:14], tone_duty[45:30],
                                            // ones_digit[49:46], tens_digit[53:50],
                                            // hundreds_digit[57:54], digit_count[59:58]
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SAMPLE_W-1:0] csr_data     // max_distance
);

   localparam int SUM_W = SAMPLE_W + $clog2(AVG_DEPTH);
   localparam int AVG_SHIFT = SUM_W + $clog2(AVG_DEPTH);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((2 ** AVG_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);
   localparam int ECHO_PROD_W = COUNT_W + ECHO_RECIP_W;

   logic                  adv;
   logic                  s1_valid_ff;
   logic                  s2_valid_ff;
   logic                  s3_valid_ff;
   logic                  s4_valid_ff;
   logic                  rsp_valid_ff;
   logic [COUNT_W-1:0]    travel_ff;
   logic [ECHO_PROD_W-1:0] echo_prod;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic [SUM_W-1:0]      sum;
   logic [PROD_W-1:0]     mean_prod;
   logic [SAMPLE_W-1:0]   mean;
   logic [SAMPLE_W-1:0]   dist_in;
   logic [SAMPLE_W-1:0]   dist_ff;
   logic [SAMPLE_W-1:0]   max_dist_ff;
   result_type            result;
   result_type            rsp_ff;

   // whole pipeline moves when the output register is free
   assign adv = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready = 1'b1;

   // clamp register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= MAX_DIST_RESET;
      end else if (csr_valid) begin
         max_dist_ff <= csr_data;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   // travel / 58 by reciprocal
   assign echo_prod = ECHO_PROD_W'(travel_ff) * ECHO_PROD_W'(ECHO_RECIP);

   // mean of the history by reciprocal, then clamp
   assign mean_prod = PROD_W'(sum) * PROD_W'(AVG_RECIP);
   assign mean = mean_prod[AVG_SHIFT +: SAMPLE_W];
   assign dist_in = (mean > max_dist_ff) ? max_dist_ff : mean;

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         travel_ff <= req_tdata[31:16] - req_tdata[15:0];
         sample_ff <= echo_prod[ECHO_SHIFT +: SAMPLE_W];
         dist_ff <= dist_in;
         rsp_ff <= result;
      end
   end

   // history cells with running sum
   ura_history #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .shift_en (adv && s2_valid_ff),
      .sample   (sample_ff),
      .sum      (sum)
   );

   // level, tone and digits
   ura_format u_format (
      .dist_cm (dist_ff),
      .result  (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_ff;

endmodule

// ----- hdl/ura_checker.sv -----
module ura_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word shown after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // input side only backs up behind a stalled output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output stall");

   // silent level carries no tone
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13:11] == 3'd0 |-> rsp_tdata[45:14] == 32'd0)
      else $error("tone set at level zero");

   // digit count agrees with the distance; ones and tens digits are decimal
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[10:0] > 11'd99) == (rsp_tdata[59:58] == 2'd3))
         && rsp_tdata[49:46] <= 4'd9 && rsp_tdata[53:50] <= 4'd9)
      else $error("digit fields inconsistent with distance");

endmodule

bind ultrasonic_range_alarm_unit ura_checker u_checker (.*);
